>>> rtl/assert_macros.svh
// Assertion macros for the RTL; included by placement_degree_evaluator_top.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_SYNC(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_CLK(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) else $error("assertion failed");
`else
`define ASSERT_SYNC(lbl, prop)
`define ASSERT_CLK(lbl, prop)
`endif
`endif

>>> rtl/pdeg_pkg.sv
// ----------------------------------------------------------------------------
// pdeg_pkg
// Types and constants of the placement degree evaluator.
// ----------------------------------------------------------------------------
package pdeg_pkg;

    // commands
    localparam logic [1:0] CMD_STORE = 2'd0;
    localparam logic [1:0] CMD_EVAL  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OVERLAP = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_CX = 2'd0;
    localparam logic [1:0] REG_CY = 2'd1;
    localparam logic [1:0] REG_CW = 2'd2;
    localparam logic [1:0] REG_CH = 2'd3;

    localparam logic [32:0] ONE_Q16 = 33'h0_0001_0000;
    localparam logic [32:0] DEG_MIN = 33'h1_0000_0000;
    localparam logic [33:0] SQ_NONE = '1;

    typedef struct packed {
        logic signed [14:0] x;
        logic signed [14:0] y;
        logic [13:0]        w;
        logic [13:0]        h;
    } t_box;

    // request into the gap unit
    typedef struct packed {
        logic               valid;
        logic               cont;   // container gap instead of stored entry
        logic signed [17:0] cgap;
    } t_gap_in;

    // result of the gap unit
    typedef struct packed {
        logic        valid;
        logic        ovl;
        logic [33:0] sq;
    } t_gap_out;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CONT  = 8'b0000_0010,
        S_SCAN  = 8'b0000_0100,
        S_DRAIN = 8'b0000_1000,
        S_PICK  = 8'b0001_0000,
        S_ROOT  = 8'b0010_0000,
        S_DIV   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

endpackage

>>> rtl/pdeg_cell.sv
// ----------------------------------------------------------------------------
// pdeg_cell
// One cell of the rectangle chain: holds one entry, takes its neighbor's.
// ----------------------------------------------------------------------------
module pdeg_cell (
    input  logic           i_clk,
    input  logic           i_en,
    input  pdeg_pkg::t_box i_d,
    output pdeg_pkg::t_box o_q
);

    pdeg_pkg::t_box r_q;

    // shift on store or rotate
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

>>> rtl/pdeg_gap.sv
// ----------------------------------------------------------------------------
// pdeg_gap
// Two-stage squared gap and overlap check of the candidate against one entry.
// ----------------------------------------------------------------------------
module pdeg_gap (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pdeg_pkg::t_box     i_cand,
    input  pdeg_pkg::t_box     i_ent,
    input  pdeg_pkg::t_gap_in  i_in,
    output pdeg_pkg::t_gap_out o_out
);

    logic signed [17:0] rx, rx2, ry, ry2, ox, ox2, oy, oy2;
    logic signed [17:0] dx1, dx2, dy1, dy2, gx, gy;
    logic               ovl;
    logic               r_v, r_ovl;
    logic [15:0]        r_dx, r_dy;
    pdeg_pkg::t_gap_out r_out;

    // extents and axis gaps
    always_comb begin
        rx  = 18'(i_cand.x);
        ry  = 18'(i_cand.y);
        rx2 = rx + 18'(i_cand.w);
        ry2 = ry + 18'(i_cand.h);
        ox  = 18'(i_ent.x);
        oy  = 18'(i_ent.y);
        ox2 = ox + 18'(i_ent.w);
        oy2 = oy + 18'(i_ent.h);
        dx1 = rx - ox2;
        dx2 = ox - rx2;
        dy1 = ry - oy2;
        dy2 = oy - ry2;
        ovl = !(rx2 <= ox || rx >= ox2 || ry2 <= oy || ry >= oy2);
        gx  = (dx1 > dx2) ? dx1 : dx2;
        gy  = (dy1 > dy2) ? dy1 : dy2;
        if (i_in.cont) begin
            gx  = i_in.cgap;
            gy  = '0;
            ovl = 1'b0;
        end
        if (gx < 0) gx = '0;
        if (gy < 0) gy = '0;
    end

    // stage 1: gaps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= i_in.valid;
        end
        r_ovl <= ovl;
        r_dx  <= gx[15:0];
        r_dy  <= gy[15:0];
    end

    // stage 2: squares
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else begin
            r_out.valid <= r_v;
        end
        r_out.ovl <= r_ovl;
        r_out.sq  <= 34'(32'(r_dx) * 32'(r_dx)) + 34'(32'(r_dy) * 32'(r_dy));
    end

    assign o_out = r_out;

endmodule

>>> rtl/pdeg_isqrt.sv
// ----------------------------------------------------------------------------
// pdeg_isqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module pdeg_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [33:0] i_val,
    output logic        o_done,
    output logic [16:0] o_root
);

    logic [33:0] r_op;
    logic [19:0] r_rem;
    logic [16:0] r_root;
    logic [4:0]  r_cnt;
    logic        r_busy, r_done;
    logic [21:0] rem2, trial;

    always_comb begin
        rem2  = {r_rem, r_op[33:32]};
        trial = {3'b000, r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 5'd1) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_start) begin
            r_op   <= i_val;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= 5'd17;
        end else if (r_busy) begin
            r_op  <= {r_op[31:0], 2'b00};
            r_cnt <= r_cnt - 5'd1;
            if (rem2 >= trial) begin
                r_rem  <= 20'(rem2 - trial);
                r_root <= {r_root[15:0], 1'b1};
            end else begin
                r_rem  <= rem2[19:0];
                r_root <= {r_root[15:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

>>> rtl/pdeg_div.sv
// ----------------------------------------------------------------------------
// pdeg_div
// Restoring divider, 33-bit dividend by 15-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module pdeg_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [32:0] i_num,
    input  logic [14:0] i_den,
    output logic        o_done,
    output logic [32:0] o_quo
);

    logic [32:0] r_num, r_q;
    logic [14:0] r_rem, r_den;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;
    logic [15:0] rem2;
    logic        ge;

    always_comb begin
        rem2 = {r_rem, r_num[32]};
        ge   = rem2 >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 6'd1) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_q   <= '0;
            r_cnt <= 6'd33;
        end else if (r_busy) begin
            r_num <= {r_num[31:0], 1'b0};
            r_q   <= {r_q[31:0], ge};
            r_rem <= ge ? 15'(rem2 - {1'b0, r_den}) : rem2[14:0];
            r_cnt <= r_cnt - 6'd1;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

>>> rtl/placement_degree_evaluator_top.sv
// Store, clear and unused commands: result word registered in the cycle after accept.
// Evaluate: 4 container gaps, one chain rotation, gap pipe drain, PICK, square root,
//   divide (root and divide only when the candidate is eligible), DONE, to the result word.
// One item at a time: no new word is taken until an evaluate has returned to idle.
// Reset (synchronous, active low) empties the table and loads the container
//   defaults; table contents are not cleared.
// ----------------------------------------------------------------------------
// placement_degree_evaluator_top
// Keeps placed rectangles in a chain of cells and scores candidate placements.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module placement_degree_evaluator_top #(
    parameter int MAX_PLACED = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // cmd[1:0], rect_x[16:2], rect_y[31:17], rect_w[45:32], rect_h[59:46]
    input  logic [63:0] s_axis_tdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // status[1:0], min_distance[17:2], degree_q16[50:18], entry_count[57:51]
    output logic [63:0] m_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [14:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_PLACED + 1);
    localparam logic [CW:0] LAST = (CW + 1)'(MAX_PLACED - 1);
    localparam logic [CW-1:0] FULL = CW'(MAX_PLACED);

    pdeg_pkg::t_state   r_state, n_state;
    logic signed [14:0] r_cx, r_cy;
    logic [13:0]        r_cw, r_ch;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_step;
    logic [1:0]         r_sub;
    pdeg_pkg::t_box     r_cand, in_box;
    logic [1:0]         in_cmd;
    logic               accept;

    logic               r_hit;
    logic [1:0]         r_zeros;
    logic [33:0]        r_best;
    logic [15:0]        r_dist;
    logic [32:0]        r_deg;

    logic               r_ovalid;
    logic [1:0]         r_o_status;
    logic [15:0]        r_o_dist;
    logic [32:0]        r_o_deg;
    logic [6:0]         r_o_cnt;
    logic               out_free;

    pdeg_pkg::t_box     w_cell [MAX_PLACED];
    logic               shift_en, rotate;
    pdeg_pkg::t_box     cell0_d;

    pdeg_pkg::t_gap_in  gap_in;
    pdeg_pkg::t_gap_out gap_out;
    logic signed [17:0] cg;

    logic               root_start, root_done, div_start, div_done;
    logic [16:0]        root;
    logic [15:0]        root_sat;
    logic [32:0]        quo;
    logic [14:0]        per;
    logic               eligible;

    // input unpacking
    assign in_cmd   = s_axis_tdata[1:0];
    assign in_box.x = s_axis_tdata[16:2];
    assign in_box.y = s_axis_tdata[31:17];
    assign in_box.w = s_axis_tdata[45:32];
    assign in_box.h = s_axis_tdata[59:46];

    assign out_free      = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == pdeg_pkg::S_IDLE) && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0;
            r_cy <= '0;
            r_cw <= 14'd1024;
            r_ch <= 14'd1024;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pdeg_pkg::REG_CX: r_cx <= i_cfg_data;
                pdeg_pkg::REG_CY: r_cy <= i_cfg_data;
                pdeg_pkg::REG_CW: r_cw <= i_cfg_data[13:0];
                pdeg_pkg::REG_CH: r_ch <= i_cfg_data[13:0];
                default: ;
            endcase
        end
    end

    // cell chain: store shifts a new entry in, evaluate rotates it once
    assign shift_en = accept && in_cmd == pdeg_pkg::CMD_STORE && r_count != FULL;
    assign rotate   = (r_state == pdeg_pkg::S_SCAN);
    assign cell0_d  = rotate ? w_cell[MAX_PLACED-1] : in_box;

    for (genvar g = 0; g < MAX_PLACED; g++) begin : g_cell
        pdeg_cell u_cell (
            .i_clk (i_clk),
            .i_en  (shift_en || rotate),
            .i_d   ((g == 0) ? cell0_d : w_cell[(g == 0) ? 0 : g - 1]),
            .o_q   (w_cell[g])
        );
    end

    // container gaps, one per step
    always_comb begin
        case (r_sub)
            2'd0:    cg = 18'(r_cand.x) - 18'(r_cx);
            2'd1:    cg = 18'(r_cx) + 18'(r_cw) - 18'(r_cand.x) - 18'(r_cand.w);
            2'd2:    cg = 18'(r_cand.y) - 18'(r_cy);
            default: cg = 18'(r_cy) + 18'(r_ch) - 18'(r_cand.y) - 18'(r_cand.h);
        endcase
        gap_in.cont  = (r_state == pdeg_pkg::S_CONT);
        gap_in.cgap  = cg;
        gap_in.valid = gap_in.cont ||
                       (rotate && ((LAST - {1'b0, r_step}) < {1'b0, r_count}));
    end

    pdeg_gap u_gap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cand  (r_cand),
        .i_ent   (w_cell[MAX_PLACED-1]),
        .i_in    (gap_in),
        .o_out   (gap_out)
    );

    // square root and divide
    assign per        = 15'(r_cand.w) + 15'(r_cand.h);
    assign eligible   = !r_hit && r_zeros != 2'd3 && r_best != pdeg_pkg::SQ_NONE;
    assign root_start = (r_state == pdeg_pkg::S_PICK) && eligible;
    assign root_sat   = root[16] ? 16'hFFFF : root[15:0];
    assign div_start  = (r_state == pdeg_pkg::S_ROOT) && root_done &&
                        root_sat != '0 && per >= 15'd2;

    pdeg_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (root_start),
        .i_val   (r_best),
        .o_done  (root_done),
        .o_root  (root)
    );

    // dividend is taken straight from the root, r_dist loads on the same edge
    pdeg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({root_sat, 17'd0}),
        .i_den   (per),
        .o_done  (div_done),
        .o_quo   (quo)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        case (r_state)
            pdeg_pkg::S_IDLE: begin
                if (accept) begin
                    case (in_cmd)
                        pdeg_pkg::CMD_STORE: if (r_count != FULL) n_count = r_count + 1'b1;
                        pdeg_pkg::CMD_CLEAR: n_count = '0;
                        pdeg_pkg::CMD_EVAL:  n_state = pdeg_pkg::S_CONT;
                        default: ;
                    endcase
                end
            end
            pdeg_pkg::S_CONT:  if (r_sub == 2'd3) n_state = pdeg_pkg::S_SCAN;
            pdeg_pkg::S_SCAN:  if (r_step == LAST[CW-1:0]) n_state = pdeg_pkg::S_DRAIN;
            pdeg_pkg::S_DRAIN: if (r_sub == 2'd1) n_state = pdeg_pkg::S_PICK;
            pdeg_pkg::S_PICK:  n_state = eligible ? pdeg_pkg::S_ROOT : pdeg_pkg::S_DONE;
            pdeg_pkg::S_ROOT:  if (root_done)
                                   n_state = div_start ? pdeg_pkg::S_DIV : pdeg_pkg::S_DONE;
            pdeg_pkg::S_DIV:   if (div_done) n_state = pdeg_pkg::S_DONE;
            pdeg_pkg::S_DONE:  if (out_free) n_state = pdeg_pkg::S_IDLE;
            default:           n_state = pdeg_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pdeg_pkg::S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // step counters, candidate and accumulators
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cand <= in_box;
        end
        if (r_state != n_state) begin
            r_sub  <= '0;
            r_step <= '0;
        end else begin
            r_sub  <= r_sub + 2'd1;
            r_step <= r_step + 1'b1;
        end
        if (accept) begin
            r_hit   <= 1'b0;
            r_zeros <= '0;
            r_best  <= pdeg_pkg::SQ_NONE;
        end else if (gap_out.valid) begin
            if (gap_out.ovl) begin
                r_hit <= 1'b1;
            end else if (gap_out.sq == '0) begin
                if (r_zeros != 2'd3) r_zeros <= r_zeros + 2'd1;
            end else if (gap_out.sq < r_best) begin
                r_best <= gap_out.sq;
            end
        end
        if (r_state == pdeg_pkg::S_PICK) begin
            r_dist <= '0;
            r_deg  <= pdeg_pkg::ONE_Q16;
        end else if (r_state == pdeg_pkg::S_ROOT && root_done) begin
            r_dist <= root_sat;
            if (root_sat != '0 && per < 15'd2) r_deg <= pdeg_pkg::DEG_MIN;
        end else if (r_state == pdeg_pkg::S_DIV && div_done) begin
            r_deg <= pdeg_pkg::ONE_Q16 - quo;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if ((accept && in_cmd != pdeg_pkg::CMD_EVAL) ||
                     (r_state == pdeg_pkg::S_DONE && out_free)) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
        if (accept && in_cmd != pdeg_pkg::CMD_EVAL) begin
            r_o_status <= (in_cmd == pdeg_pkg::CMD_STORE && r_count == FULL) ?
                          pdeg_pkg::ST_FULL : pdeg_pkg::ST_OK;
            r_o_dist   <= '0;
            r_o_deg    <= pdeg_pkg::ONE_Q16;
            r_o_cnt    <= 7'(n_count);
        end else if (r_state == pdeg_pkg::S_DONE && out_free) begin
            r_o_status <= r_hit ? pdeg_pkg::ST_OVERLAP : pdeg_pkg::ST_OK;
            r_o_dist   <= r_hit ? 16'd0 : r_dist;
            r_o_deg    <= r_hit ? pdeg_pkg::ONE_Q16 : r_deg;
            r_o_cnt    <= 7'(r_count);
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'd0, r_o_cnt, r_o_deg, r_o_dist, r_o_status};

    `ASSERT_SYNC(a_count_max, r_count <= FULL)
    `ASSERT_SYNC(a_count_hold, r_state != pdeg_pkg::S_IDLE |=> r_count == $past(r_count))
    `ASSERT_SYNC(a_gap_window, gap_out.valid |-> (r_state == pdeg_pkg::S_CONT ||
                 r_state == pdeg_pkg::S_SCAN || r_state == pdeg_pkg::S_DRAIN))

endmodule

>>> sim/placement_degree_evaluator_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// placement_degree_evaluator_top_test
// Drives store, clear, evaluate and unused command words into the evaluator, predicts each
// result word from its own table and container copy, and checks every word
// in order under random idling on both stream sides.
// ----------------------------------------------------------------------------
module placement_degree_evaluator_top_test;

    localparam int N_PLACED = 64;

    // command code with no action in the block; it still returns a result word
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // laid out as the result tdata, entry count in the top bits
    typedef struct packed {
        logic [6:0]  count;
        logic [32:0] degree;
        logic [15:0] min_dist;
        logic [1:0]  status;
    } t_score;

    logic        i_clk;
    logic        i_rst_n;
    logic [63:0] s_axis_tdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [14:0] i_cfg_data;

    // predictor state
    pdeg_pkg::t_box boxes [N_PLACED];
    int          box_count;
    longint      cx, cy, cw, ch;

    t_score      score_q [$];
    int          errors;
    int          send_idle_pct;
    int          recv_idle_pct;

    placement_degree_evaluator_top #(.MAX_PLACED(N_PLACED)) i_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("[placement_degree_evaluator_top] ERROR");
        $finish;
    end

    function automatic longint isqrt(longint v);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic longint max3(longint a, longint b, longint c);
        longint m;
        m = a > b ? a : b;
        return m > c ? m : c;
    endfunction

    // compute the expected result word and update the table copy
    function automatic t_score score_word(logic [1:0] cmd, pdeg_pkg::t_box r);
        t_score s;
        longint rx, ry, rw, rh, ox, oy, ow, oh, g, best, sq, dx, dy, d, q;
        longint gaps [4];
        int     zeros;
        bit     hit;
        s = '0;
        s.degree = pdeg_pkg::ONE_Q16;
        rx = r.x; ry = r.y; rw = r.w; rh = r.h;
        if (cmd == pdeg_pkg::CMD_STORE) begin
            if (box_count < N_PLACED) begin
                boxes[box_count] = r;
                box_count++;
            end else begin
                s.status = pdeg_pkg::ST_FULL;
            end
        end else if (cmd == pdeg_pkg::CMD_CLEAR) begin
            box_count = 0;
        end else if (cmd == pdeg_pkg::CMD_EVAL) begin
            best = -1;
            zeros = 0;
            hit = 0;
            gaps[0] = rx - cx;
            gaps[1] = (cx + cw) - (rx + rw);
            gaps[2] = ry - cy;
            gaps[3] = (cy + ch) - (ry + rh);
            foreach (gaps[i]) begin
                g = gaps[i] > 0 ? gaps[i] : 0;
                if (g == 0) zeros++;
                else if (best < 0 || g * g < best) best = g * g;
            end
            for (int i = 0; i < box_count; i++) begin
                ox = boxes[i].x;
                oy = boxes[i].y;
                ow = boxes[i].w;
                oh = boxes[i].h;
                if (!(rx + rw <= ox || rx >= ox + ow ||
                      ry + rh <= oy || ry >= oy + oh)) begin
                    hit = 1;
                    continue;
                end
                dx = max3(rx - (ox + ow), ox - (rx + rw), 0);
                dy = max3(ry - (oy + oh), oy - (ry + rh), 0);
                sq = dx * dx + dy * dy;
                if (sq == 0) zeros++;
                else if (best < 0 || sq < best) best = sq;
            end
            if (hit) begin
                s.status = pdeg_pkg::ST_OVERLAP;
            end else if (zeros <= 2 && best >= 0) begin
                d = isqrt(best);
                if (d > 65535) d = 65535;
                s.min_dist = d[15:0];
                if (d != 0) begin
                    if (rw + rh < 2) begin
                        s.degree = pdeg_pkg::DEG_MIN;
                    end else begin
                        q = (d * 2 * 65536) / (rw + rh);
                        s.degree = 33'(65536 - q);
                    end
                end
            end
        end
        s.count = box_count[6:0];
        return s;
    endfunction

    // tvalid stays high into the next word unless the sender idles
    task automatic send_word(logic [1:0] cmd, pdeg_pkg::t_box r);
        t_score exp_word;
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tdata <= {4'd0, r.h, r.w, r.y, r.x, cmd};
        s_axis_tvalid <= 1'b1;
        exp_word = score_word(cmd, r);
        score_q = {score_q, exp_word};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_fields(logic [1:0] cmd, int x, int y, int w, int h);
        pdeg_pkg::t_box r;
        r.x = 15'(x); r.y = 15'(y); r.w = 14'(w); r.h = 14'(h);
        send_word(cmd, r);
    endtask

    // wait for every word, then for the longest evaluation
    task automatic drain;
        int n;
        n = 0;
        s_axis_tvalid <= 1'b0;
        while (score_q.size() != 0 && n < 200000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (N_PLACED + 120) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= 15'(value);
        @(posedge i_clk);
        case (idx)
            pdeg_pkg::REG_CX: cx = longint'(signed'(15'(value)));
            pdeg_pkg::REG_CY: cy = longint'(signed'(15'(value)));
            pdeg_pkg::REG_CW: cw = value & 16'h3FFF;
            default: ch = value & 16'h3FFF;
        endcase
    endtask

    task automatic set_container(int x, int y, int w, int h);
        drain();
        write_reg(pdeg_pkg::REG_CX, x);
        write_reg(pdeg_pkg::REG_CY, y);
        write_reg(pdeg_pkg::REG_CW, w);
        write_reg(pdeg_pkg::REG_CH, h);
        i_cfg_we <= 1'b0;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_score got;
        t_score want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[57:0];
            if (score_q.size() == 0) begin
                $display("%t unexpected word exp none got %h", $time, got);
                errors++;
            end else begin
                want = score_q.pop_front();
                if (got.status !== want.status)
                    $display("%t status exp %0d got %0d", $time, want.status, got.status);
                if (got.min_dist !== want.min_dist)
                    $display("%t distance exp %0d got %0d", $time, want.min_dist,
                             got.min_dist);
                if (got.degree !== want.degree)
                    $display("%t degree exp %h got %h", $time, want.degree, got.degree);
                if (got.count !== want.count)
                    $display("%t count exp %0d got %0d", $time, want.count, got.count);
                if (got !== want) errors++;
            end
        end
    end

    // receiver stall
    always @(posedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic test_directed;
        send_fields(pdeg_pkg::CMD_EVAL, 100, 100, 10, 20);
        send_fields(pdeg_pkg::CMD_EVAL, 0, 0, 1024, 1024);
        send_fields(pdeg_pkg::CMD_EVAL, -16384, -16384, 16383, 16383);
        send_fields(pdeg_pkg::CMD_EVAL, 16383, 16383, 16383, 16383);
        send_fields(pdeg_pkg::CMD_STORE, 0, 0, 100, 100);
        send_fields(pdeg_pkg::CMD_EVAL, 50, 50, 10, 10);
        send_fields(pdeg_pkg::CMD_EVAL, 100, 0, 50, 100);
        send_fields(pdeg_pkg::CMD_STORE, 200, 0, 100, 100);
        send_fields(pdeg_pkg::CMD_EVAL, 100, 0, 100, 100);
        send_fields(pdeg_pkg::CMD_EVAL, 500, 500, 1, 1);
        send_fields(CMD_UNUSED, 1, 2, 3, 4);
        send_fields(pdeg_pkg::CMD_CLEAR, 0, 0, 1, 1);
        for (int i = 0; i < N_PLACED + 2; i++)
            send_fields(pdeg_pkg::CMD_STORE, (i % 8) * 120, (i / 8) * 120, 100, 100);
        send_fields(pdeg_pkg::CMD_EVAL, 105, 105, 10, 10);
        send_fields(pdeg_pkg::CMD_CLEAR, 0, 0, 1, 1);
        set_container(-16384, -16384, 16383, 16383);
        send_fields(pdeg_pkg::CMD_EVAL, 0, 0, 1, 1);
        send_fields(pdeg_pkg::CMD_EVAL, -16384, -16384, 1, 1);
        set_container(16383, 16383, 1, 1);
        send_fields(pdeg_pkg::CMD_EVAL, 0, 0, 16383, 16383);
    endtask

    task automatic test_random(int count);
        int k, cmd, span, x0, y0;
        k = 0;
        while (k < count) begin
            span = ($urandom_range(9) == 0) ? 16383 : 400;
            x0 = $urandom_range(2) == 0 ? int'($urandom_range(32767)) - 16384 : 0;
            y0 = $urandom_range(2) == 0 ? int'($urandom_range(32767)) - 16384 : 0;
            set_container(x0, y0, $urandom_range(16383, 1), $urandom_range(16383, 1));
            if ($urandom_range(3) == 0)
                set_container(x0, y0, $urandom_range(span, 1), $urandom_range(span, 1));
            for (int j = 0; j < 200 && k < count; j++, k++) begin
                cmd = $urandom_range(99);
                if (cmd < 40) cmd = pdeg_pkg::CMD_STORE;
                else if (cmd < 92) cmd = pdeg_pkg::CMD_EVAL;
                else if (cmd < 97) cmd = pdeg_pkg::CMD_CLEAR;
                else cmd = CMD_UNUSED;
                if ($urandom_range(9) == 0)
                    send_fields(2'(cmd), int'($urandom_range(32767)) - 16384,
                                int'($urandom_range(32767)) - 16384,
                                $urandom_range(16383, 1), $urandom_range(16383, 1));
                else
                    send_fields(2'(cmd), int'(cx) + int'($urandom_range(span)) - 20,
                                int'(cy) + int'($urandom_range(span)) - 20,
                                $urandom_range(span / 4 + 1, 1),
                                $urandom_range(span / 4 + 1, 1));
            end
        end
    endtask

    initial begin
        errors = 0;
        box_count = 0;
        cx = 0; cy = 0; cw = 1024; ch = 1024;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n = 1'b0;
        s_axis_tdata = '0;
        s_axis_tvalid = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = pdeg_pkg::REG_CX;
        i_cfg_data = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 6;
        recv_idle_pct = 79;
        test_directed();
        test_random(600);
        send_idle_pct = 79;
        recv_idle_pct = 6;
        test_random(700);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(700);
        drain();

        if (errors == 0 && score_q.size() == 0) begin
            $display("[placement_degree_evaluator_top] OK");
        end else begin
            $display("[placement_degree_evaluator_top] ERROR");
        end
        $finish;
    end
endmodule
